// ----- src/cesc_pkg.sv -----
// Shared types, constants and character helpers for the C escape line wrapper.
package cesc_pkg;

   localparam int BYTE_W      = 8;
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 16;
   localparam int COL_W       = 16;
   localparam int TOKEN_MAX   = 5;   // wrap newline plus a four character escape
   localparam int LEN_W       = 3;
   localparam int QUEUE_DEPTH = 4;
   localparam logic [COL_W-1:0] LINE_LIMIT_RESET = 16'd80;

   typedef logic [BYTE_W-1:0] byte_type;

   typedef enum logic {
      OP_DATA = 1'b0,
      OP_EOS  = 1'b1
   } opcode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_LINE_LIMIT          = 8'd0,
      REG_NEWLINE_PASSTHROUGH = 8'd1,
      REG_ESCAPE_QUOTES       = 8'd2,
      REG_HEX_MODE            = 8'd3
   } csr_index_type;

   localparam byte_type CH_LF     = 8'h0A;
   localparam byte_type CH_SPACE  = 8'h20;
   localparam byte_type CH_DQUOTE = 8'h22;
   localparam byte_type CH_APOS   = 8'h27;
   localparam byte_type CH_ZERO   = 8'h30;
   localparam byte_type CH_QMARK  = 8'h3F;
   localparam byte_type CH_BSLASH = 8'h5C;
   localparam byte_type CH_LOWA   = 8'h61;
   localparam byte_type CH_X      = 8'h78;
   localparam byte_type CH_TILDE  = 8'h7E;
   localparam byte_type CH_BEL    = 8'h07;
   localparam byte_type CH_CR     = 8'h0D;

   // One output token: chars[0] goes out first, len counts 1 to TOKEN_MAX.
   typedef struct packed {
      logic [LEN_W-1:0]                 len;
      logic [TOKEN_MAX-1:0][BYTE_W-1:0] chars;
   } token_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   function automatic byte_type hex_digit(input logic [3:0] nib);
      byte_type c;
      if (nib < 4'd10) begin
         c = CH_ZERO + {4'd0, nib};
      end else begin
         c = CH_LOWA + {4'd0, nib} - 8'd10;
      end
      return c;
   endfunction

   // Letters for BEL through CR.
   function automatic byte_type ctl_letter(input byte_type b);
      byte_type c;
      case (b)
         8'h07:   c = 8'h61; // a
         8'h08:   c = 8'h62; // b
         8'h09:   c = 8'h74; // t
         8'h0A:   c = 8'h6E; // n
         8'h0B:   c = 8'h76; // v
         8'h0C:   c = 8'h66; // f
         8'h0D:   c = 8'h72; // r
         default: c = 8'h3F;
      endcase
      return c;
   endfunction

endpackage

// ----- src/cesc_if.sv -----
// Channel interfaces: request, response and register write.
interface cesc_req_if;
   import cesc_pkg::*;
   logic       valid;
   logic       ready;
   logic       opcode;
   byte_type   data_byte;
   modport source (output valid, output opcode, output data_byte, input ready);
   modport sink   (input valid, input opcode, input data_byte, output ready);
endinterface

interface cesc_rsp_if;
   import cesc_pkg::*;
   logic       valid;
   logic       ready;
   byte_type   out_char;
   logic       last_of_run;
   modport source (output valid, output out_char, output last_of_run, input ready);
   modport sink   (input valid, input out_char, input last_of_run, output ready);
endinterface

interface cesc_csr_if;
   import cesc_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- src/cesc_front.sv -----
// Front end: registers, input acceptance, token building and line tracking.
module cesc_front (
   input  logic                       clock,
   input  logic                       reset,
   cesc_req_if.sink                   req,
   cesc_csr_if.sink                   csr,
   input  cesc_pkg::queue_status_type q_status,
   output logic                       push,
   output cesc_pkg::token_type        push_token
);
   import cesc_pkg::*;

   logic [COL_W-1:0] line_limit_ff;
   logic             passthrough_ff;
   logic             escape_quotes_ff;
   logic             hex_mode_ff;
   logic [COL_W-1:0] col_ff, col_in;
   logic             ale_ff, ale_in;

   logic                      accept;
   byte_type                  b;
   logic                      quote;
   logic                      hexform;
   logic [3:0][BYTE_W-1:0]    tok;
   logic [LEN_W-1:0]          tlen;
   logic [COL_W:0]            sum;
   logic                      wrap;

   assign req.ready = !q_status.full;
   assign csr.ready = 1'b1;
   assign accept    = req.valid && req.ready;
   assign b         = req.data_byte;

   // register writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         line_limit_ff    <= LINE_LIMIT_RESET;
         passthrough_ff   <= 1'b0;
         escape_quotes_ff <= 1'b0;
         hex_mode_ff      <= 1'b0;
      end else if (csr.valid) begin
         case (csr.index)
            REG_LINE_LIMIT:          line_limit_ff    <= csr.data;
            REG_NEWLINE_PASSTHROUGH: passthrough_ff   <= csr.data[0];
            REG_ESCAPE_QUOTES:       escape_quotes_ff <= csr.data[0];
            REG_HEX_MODE:            hex_mode_ff      <= csr.data[0];
            default: ;
         endcase
      end
   end

   // token for a data byte
   always_comb begin
      quote   = escape_quotes_ff && (b == CH_DQUOTE || b == CH_APOS || b == CH_QMARK);
      hexform = 1'b0;
      tok     = '0;
      tlen    = 3'd1;
      if (b == 8'h00) begin
         if (hex_mode_ff) begin
            hexform = 1'b1;
         end else begin
            tok[0] = CH_BSLASH;
            tok[1] = CH_ZERO;
            tlen   = 3'd2;
         end
      end else if (b inside {[CH_BEL:CH_CR]}) begin
         if (hex_mode_ff) begin
            hexform = 1'b1;
         end else begin
            tok[0] = CH_BSLASH;
            tok[1] = ctl_letter(b);
            tlen   = 3'd2;
         end
      end else if (b == CH_BSLASH || quote) begin
         if (hex_mode_ff) begin
            hexform = 1'b1;
         end else begin
            tok[0] = CH_BSLASH;
            tok[1] = b;
            tlen   = 3'd2;
         end
      end else if (b inside {[CH_SPACE:CH_TILDE]}) begin
         tok[0] = b;
         tlen   = 3'd1;
      end else begin
         hexform = 1'b1;
      end
      if (hexform) begin
         tok[0] = CH_BSLASH;
         tok[1] = CH_X;
         tok[2] = hex_digit(b[7:4]);
         tok[3] = hex_digit(b[3:0]);
         tlen   = 3'd4;
      end
   end

   assign sum  = {1'b0, col_ff} + (COL_W + 1)'(tlen);
   assign wrap = (line_limit_ff != '0) && (sum > {1'b0, line_limit_ff});

   always_comb begin
      col_in     = col_ff;
      ale_in     = ale_ff;
      push       = 1'b0;
      push_token = '0;
      if (accept) begin
         if (req.opcode == OP_EOS) begin
            if (line_limit_ff != '0 && col_ff != '0 && !ale_ff) begin
               push                = 1'b1;
               push_token.len      = 3'd1;
               push_token.chars[0] = CH_LF;
               col_in              = '0;
               ale_in              = 1'b1;
            end
         end else if (b == CH_LF && passthrough_ff) begin
            if (!ale_ff) begin
               push                = 1'b1;
               push_token.len      = 3'd1;
               push_token.chars[0] = CH_LF;
            end
            ale_in = 1'b1;
            col_in = '0;
         end else begin
            push   = 1'b1;
            ale_in = 1'b0;
            if (wrap) begin
               push_token.chars[0]   = CH_LF;
               push_token.chars[4:1] = tok;
               push_token.len        = tlen + 3'd1;
               col_in                = COL_W'(tlen);
            end else begin
               push_token.chars[3:0] = tok;
               push_token.len        = tlen;
               col_in                = sum[COL_W] ? '1 : sum[COL_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         ale_ff <= 1'b0;
      end else begin
         col_ff <= col_in;
         ale_ff <= ale_in;
      end
   end

endmodule

// ----- src/cesc_queue.sv -----
// Token queue between the front and back ends.
module cesc_queue #(
   parameter int QueueDepth = cesc_pkg::QUEUE_DEPTH
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  cesc_pkg::token_type         push_token,
   input  logic                        pop,
   output cesc_pkg::token_type         head,
   output cesc_pkg::queue_status_type  status
);
   import cesc_pkg::*;

   localparam int PTR_W = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int CNT_W = $clog2(QueueDepth + 1);

   token_type        entries [QueueDepth];
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   assign status.empty = (cnt_ff == '0);
   assign status.full  = (cnt_ff == CNT_W'(QueueDepth));
   assign head         = entries[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_W'(QueueDepth - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_W'(QueueDepth - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries[wr_ff] <= push_token;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ----- src/cesc_back.sv -----
// Back end: walks the head token one character per cycle, unless the receiver stalls, into the output register.
module cesc_back (
   input  logic                       clock,
   input  logic                       reset,
   input  cesc_pkg::token_type        head,
   input  cesc_pkg::queue_status_type q_status,
   output logic                       pop,
   cesc_rsp_if.source                 rsp
);
   import cesc_pkg::*;

   logic             valid_ff, valid_in;
   byte_type         char_ff, char_in;
   logic             last_ff, last_in;
   logic [LEN_W-1:0] idx_ff, idx_in;
   logic             load;
   logic             take;
   logic             at_last;

   assign load    = !valid_ff || rsp.ready;
   assign take    = load && !q_status.empty;
   assign at_last = (idx_ff == head.len - 3'd1);
   assign pop     = take && at_last;

   always_comb begin
      valid_in = valid_ff;
      char_in  = char_ff;
      last_in  = last_ff;
      idx_in   = idx_ff;
      if (load) begin
         valid_in = !q_status.empty;
      end
      if (take) begin
         char_in = head.chars[idx_ff];
         last_in = at_last;
         idx_in  = at_last ? '0 : idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign rsp.valid       = valid_ff;
   assign rsp.out_char    = char_ff;
   assign rsp.last_of_run = last_ff;

endmodule

// ----- src/c_escape_line_wrapper.sv -----
// Top level of the C escape encoder with line wrapping.
//
// Channels: req_ch carries one raw byte (or an end-of-stream marker) per
// transaction; rsp_ch carries one character of escaped text per transaction,
// with last_of_run set on the final character caused by that input; csr_ch
// writes the four registers (line limit, newline passthrough, escape quotes,
// hex mode) and is always ready. Write registers only while the block is idle.
// An accepted item's token is written into the queue, and the back end then
// moves its first character into the output register. Throughput: one character
// per cycle on rsp_ch while the receiver is ready, and an item yields up to five
// characters (wrap newline plus a \xHH escape is the worst). The back end's
// serialiser sets that rate; items that produce nothing push no token.
// The front end builds a whole token per item and keeps the column count; a
// queue of QueueDepth tokens lets it run ahead of the serialiser.
// Reset (synchronous, active high) empties the queue, clears the column and
// line-end state and restores the registers to their defaults (limit 80).
// When the receiver stalls, the output register holds its character, the
// queue fills and req_ch.ready falls once it is full.
module c_escape_line_wrapper #(
   parameter int QueueDepth = cesc_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   cesc_req_if.sink   req_ch,
   cesc_rsp_if.source rsp_ch,
   cesc_csr_if.sink   csr_ch
);
   import cesc_pkg::*;

   queue_status_type q_status;
   token_type        push_token;
   token_type        head;
   logic             push;
   logic             pop;

   // front end: classify, escape, wrap
   cesc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .csr        (csr_ch),
      .q_status   (q_status),
      .push       (push),
      .push_token (push_token)
   );

   cesc_queue #(
      .QueueDepth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_token (push_token),
      .pop        (pop),
      .head       (head),
      .status     (q_status)
   );

   // back end: serialise tokens
   cesc_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .q_status (q_status),
      .pop      (pop),
      .rsp      (rsp_ch)
   );

   // queue status must be consistent
   a_status_sane : assert property (@(posedge clock) disable iff (reset)
      !(q_status.empty && q_status.full))
      else $error("queue reports empty and full together");

   // nothing comes out straight after reset
   a_quiet_after_reset : assert property (@(posedge clock)
      $past(reset) |-> !rsp_ch.valid)
      else $error("response valid just after reset");

   // no response appears from an empty queue
   a_no_phantom : assert property (@(posedge clock) disable iff (reset)
      (!rsp_ch.valid && q_status.empty) |=> !rsp_ch.valid)
      else $error("response raised with nothing queued");

   // a pop only happens on a character actually moved out
   a_pop_nonempty : assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty)
      else $error("pop from empty queue");

endmodule
